// File: rtl/core/dawf_pkg.sv
package dawf_pkg;

  // longest word that is stored and can still match
  localparam int unsigned MaxWord  = 32;
  localparam int unsigned IdxW     = $clog2(MaxWord);
  localparam int unsigned LenW     = $clog2(MaxWord + 1);
  localparam int unsigned AddrW    = IdxW + 1;
  localparam int unsigned MemDepth = 2 ** AddrW;
  localparam int unsigned LineW    = 32;

  localparam logic [7:0]       NlByte  = 8'h0A;
  localparam logic [LineW-1:0] LineMax = '1;

  // word end that found a duplicate: report the previous word
  typedef struct packed {
    logic             start;
    logic             sel;
    logic [LenW-1:0]  len;
    logic [LineW-1:0] line;
  } emit_req_t;

endpackage

// File: rtl/core/dawf_ifs.sv
interface dawf_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       end_marker;

  modport source (output valid, output text_byte, output end_marker, input ready);
  modport sink (input valid, input text_byte, input end_marker, output ready);
endinterface

interface dawf_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  letter;
  logic [31:0] word_line;
  logic        last_letter;
  logic        pair_seen;

  modport source (output valid, output letter, output word_line, output last_letter,
                  output pair_seen, input ready);
  modport sink (input valid, input letter, input word_line, input last_letter,
                input pair_seen, output ready);
endinterface

// File: rtl/core/duplicate_adjacent_word_finder.sv
// Doubled-word finder. Takes text one byte per request and, when a word of
// ASCII letters ends and equals the word before it in the same file (case
// ignored), reports the earlier word letter by letter in its original case with
// the line it ended on; end_marker closes a file and restarts line counting at 1.
// Letters and other bytes are taken one per cycle. On a duplicate the input
// stalls while the word is read back from the 2 x MaxWord byte store: a reported
// letter takes one RAM read, then the output register, held while the output is
// held off. The store is not cleared at reset and needs no clearing pass.
module duplicate_adjacent_word_finder (
  input  logic       clk_i,
  input  logic       rst_ni,
  dawf_in_if.sink    text_i,
  dawf_out_if.source report_o
);
  import dawf_pkg::*;

  emit_req_t        emit_req;
  logic             emit_busy;
  logic             scan_we;
  logic [AddrW-1:0] scan_waddr;
  logic [7:0]       scan_wdata;
  logic             scan_re;
  logic [AddrW-1:0] scan_raddr;
  logic             emit_re;
  logic [AddrW-1:0] emit_raddr;
  logic             ram_re;
  logic [AddrW-1:0] ram_raddr;
  logic [7:0]       ram_rdata;

  // read port shared: compare reads while scanning, report reads while stalled
  assign ram_re    = scan_re || emit_re;
  assign ram_raddr = emit_re ? emit_raddr : scan_raddr;

  dawf_scan u_scan (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .text_i      (text_i),
    .emit_busy_i (emit_busy),
    .we_o        (scan_we),
    .waddr_o     (scan_waddr),
    .wdata_o     (scan_wdata),
    .re_o        (scan_re),
    .raddr_o     (scan_raddr),
    .rdata_i     (ram_rdata),
    .emit_req_o  (emit_req)
  );

  dawf_ram #(
    .Width (8),
    .Depth (MemDepth)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (scan_we),
    .waddr_i (scan_waddr),
    .wdata_i (scan_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  dawf_emit u_emit (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (emit_req),
    .busy_o   (emit_busy),
    .re_o     (emit_re),
    .raddr_o  (emit_raddr),
    .rdata_i  (ram_rdata),
    .report_o (report_o)
  );

  a_one_reader: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(scan_re && emit_re))
    else $error("both units read the store in one cycle");

endmodule

// File: rtl/core/dawf_ram.sv
module dawf_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

// File: rtl/core/dawf_scan.sv
module dawf_scan (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  dawf_in_if.sink                   text_i,
  input  logic                      emit_busy_i,
  output logic                      we_o,
  output logic [dawf_pkg::AddrW-1:0] waddr_o,
  output logic [7:0]                wdata_o,
  output logic                      re_o,
  output logic [dawf_pkg::AddrW-1:0] raddr_o,
  input  logic [7:0]                rdata_i,
  output dawf_pkg::emit_req_t       emit_req_o
);
  import dawf_pkg::*;

  function automatic logic is_letter(logic [7:0] b);
    return (b >= 8'h41 && b <= 8'h5A) || (b >= 8'h61 && b <= 8'h7A);
  endfunction

  // case fold for letters: drop the lower-case bit
  function automatic logic [6:0] fold(logic [7:0] b);
    return {b[7:6], b[4:0]};
  endfunction

  logic             sel_q, sel_d;
  logic [LenW-1:0]  cur_len_q, cur_len_d;
  logic [LenW-1:0]  prev_len_q, prev_len_d;
  logic             prev_valid_q, prev_valid_d;
  logic             cur_tl_q, cur_tl_d;
  logic             prev_tl_q, prev_tl_d;
  logic             match_q, match_d;
  logic [LineW-1:0] line_q, line_d;
  logic [LineW-1:0] prev_line_q, prev_line_d;
  logic             cmp_pend_q, cmp_pend_d;
  logic [6:0]       fold_q, fold_d;

  logic accept, letter_acc, end_acc, full, static_ok, pending, cmp_bad, eff_match, hit;

  assign text_i.ready = !emit_busy_i;
  assign accept     = text_i.valid && text_i.ready;
  assign letter_acc = accept && !text_i.end_marker && is_letter(text_i.text_byte);
  assign end_acc    = accept && (text_i.end_marker || !is_letter(text_i.text_byte));

  assign full      = (cur_len_q == LenW'(MaxWord));
  assign static_ok = prev_valid_q && !prev_tl_q && (cur_len_q < prev_len_q);
  assign pending   = (cur_len_q != '0) || cur_tl_q;

  // compare of the previous letter lands in the cycle after its request
  assign cmp_bad   = cmp_pend_q && (fold(rdata_i) != fold_q);
  assign eff_match = match_q && !cmp_bad;
  assign hit = eff_match && prev_valid_q && !prev_tl_q && !cur_tl_q &&
               (cur_len_q == prev_len_q) && (cur_len_q != '0);

  assign we_o    = letter_acc && !full;
  assign waddr_o = {sel_q, cur_len_q[IdxW-1:0]};
  assign wdata_o = text_i.text_byte;
  assign re_o    = letter_acc && !full && static_ok;
  assign raddr_o = {~sel_q, cur_len_q[IdxW-1:0]};

  assign emit_req_o.start = end_acc && pending && hit;
  assign emit_req_o.sel   = ~sel_q;
  assign emit_req_o.len   = prev_len_q;
  assign emit_req_o.line  = prev_line_q;

  always_comb begin
    sel_d        = sel_q;
    cur_len_d    = cur_len_q;
    prev_len_d   = prev_len_q;
    prev_valid_d = prev_valid_q;
    cur_tl_d     = cur_tl_q;
    prev_tl_d    = prev_tl_q;
    match_d      = eff_match;
    line_d       = line_q;
    prev_line_d  = prev_line_q;
    cmp_pend_d   = 1'b0;
    fold_d       = fold_q;

    if (letter_acc) begin
      if (full) begin
        cur_tl_d = 1'b1;
        match_d  = 1'b0;
      end else begin
        cur_len_d = cur_len_q + LenW'(1);
        if (static_ok) begin
          cmp_pend_d = 1'b1;
          fold_d     = fold(text_i.text_byte);
        end else begin
          match_d = 1'b0;
        end
      end
    end

    if (end_acc) begin
      if (pending) begin
        sel_d        = ~sel_q;
        prev_len_d   = cur_len_q;
        prev_tl_d    = cur_tl_q;
        prev_valid_d = 1'b1;
        prev_line_d  = line_q;
        cur_len_d    = '0;
        cur_tl_d     = 1'b0;
        match_d      = 1'b1;
      end
      if (text_i.end_marker) begin
        prev_valid_d = 1'b0;
        line_d       = LineW'(1);
      end else if (text_i.text_byte == NlByte && line_q != LineMax) begin
        line_d = line_q + LineW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sel_q        <= 1'b0;
      cur_len_q    <= '0;
      prev_len_q   <= '0;
      prev_valid_q <= 1'b0;
      cur_tl_q     <= 1'b0;
      prev_tl_q    <= 1'b0;
      match_q      <= 1'b1;
      line_q       <= LineW'(1);
      prev_line_q  <= LineW'(1);
      cmp_pend_q   <= 1'b0;
    end else begin
      sel_q        <= sel_d;
      cur_len_q    <= cur_len_d;
      prev_len_q   <= prev_len_d;
      prev_valid_q <= prev_valid_d;
      cur_tl_q     <= cur_tl_d;
      prev_tl_q    <= prev_tl_d;
      match_q      <= match_d;
      line_q       <= line_d;
      prev_line_q  <= prev_line_d;
      cmp_pend_q   <= cmp_pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    fold_q <= fold_d;
  end

  a_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cur_len_q <= LenW'(MaxWord))
    else $error("word length above limit");

endmodule

// File: rtl/core/dawf_emit.sv
module dawf_emit (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  dawf_pkg::emit_req_t        req_i,
  output logic                       busy_o,
  output logic                       re_o,
  output logic [dawf_pkg::AddrW-1:0] raddr_o,
  input  logic [7:0]                 rdata_i,
  dawf_out_if.source                 report_o
);
  import dawf_pkg::*;

  typedef enum logic {
    EmIdle,
    EmRead
  } em_state_e;

  em_state_e        state_q;
  logic [IdxW-1:0]  k_q;
  logic [LenW-1:0]  len_q;
  logic             sel_q;
  logic [LineW-1:0] line_q;
  logic             pair_q;
  logic             rd_pend_q;
  logic             rd_last_q;
  logic             out_v_q;
  logic [7:0]       out_letter_q;
  logic [LineW-1:0] out_line_q;
  logic             out_last_q;
  logic             out_pair_q;

  logic issue, last_issue;

  // one read at a time, only when the output register is free when it lands
  assign issue      = (state_q == EmRead) && !rd_pend_q && (!out_v_q || report_o.ready);
  assign last_issue = (LenW'(k_q) + LenW'(1)) == len_q;

  assign busy_o  = (state_q == EmRead);
  assign re_o    = issue;
  assign raddr_o = {sel_q, k_q};

  assign report_o.valid       = out_v_q;
  assign report_o.letter      = out_letter_q;
  assign report_o.word_line   = out_line_q;
  assign report_o.last_letter = out_last_q;
  assign report_o.pair_seen   = out_pair_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= EmIdle;
      k_q          <= '0;
      len_q        <= '0;
      sel_q        <= 1'b0;
      line_q       <= '0;
      pair_q       <= 1'b0;
      rd_pend_q    <= 1'b0;
      rd_last_q    <= 1'b0;
      out_v_q      <= 1'b0;
      out_letter_q <= '0;
      out_line_q   <= '0;
      out_last_q   <= 1'b0;
      out_pair_q   <= 1'b0;
    end else begin
      case (state_q)
        EmIdle: begin
          if (req_i.start) begin
            state_q <= EmRead;
            k_q     <= '0;
            len_q   <= req_i.len;
            sel_q   <= req_i.sel;
            line_q  <= req_i.line;
            pair_q  <= 1'b1;
          end
        end
        EmRead: begin
          if (issue) begin
            k_q <= k_q + IdxW'(1);
            if (last_issue) begin
              state_q <= EmIdle;
            end
          end
        end
        default: state_q <= EmIdle;
      endcase

      rd_pend_q <= issue;
      if (issue) begin
        rd_last_q <= last_issue;
      end

      if (rd_pend_q) begin
        out_v_q      <= 1'b1;
        out_letter_q <= rdata_i;
        out_line_q   <= line_q;
        out_last_q   <= rd_last_q;
        out_pair_q   <= pair_q;
      end else if (report_o.ready) begin
        out_v_q <= 1'b0;
      end
    end
  end

  a_land_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_pend_q |-> !out_v_q)
    else $error("read data lands on a full output register");

  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start |-> state_q == EmIdle)
    else $error("report started while another is in progress");

  a_pair_set: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q |-> out_pair_q)
    else $error("report without pair flag");

endmodule
